// ----- hw/rtl/weighted_geometric_mean_filter_core_defines.svh -----
// Assertion macros for the weighted geometric mean filter core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef WEIGHTED_GEOMETRIC_MEAN_FILTER_CORE_DEFINES_SVH
`define WEIGHTED_GEOMETRIC_MEAN_FILTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define WGM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define WGM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/wgm_pkg.sv -----
// Shared constants, types and the exp2 factor table of the geometric mean filter.
// No dependencies; imported by every module of the block.
package wgm_pkg;

    localparam int TAPS        = 5;
    localparam int NUM_WEIGHTS = 5;
    localparam int CENTRE      = TAPS / 2;

    localparam int SAMPLE_W    = 16;
    localparam int SAMPLE_FRAC = 12;
    localparam int WEIGHT_W    = 16;
    localparam int MSB_W       = $clog2(SAMPLE_W);

    // log2 datapath: Q1.30 mantissa squared once per step
    localparam int Z_W       = 31;
    localparam int Z_FRAC    = Z_W - 1;
    localparam int LOG_STEPS = 17;
    localparam int FRAC_W    = LOG_STEPS;
    localparam int LOG_FRAC  = 16;
    localparam int LOG_W     = 21;

    localparam int PROD_W = WEIGHT_W + LOG_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int E_W    = ACC_W - LOG_FRAC;
    localparam int N_W    = E_W - LOG_FRAC + 1;

    // exp2 datapath: Q1.30 product of table factors
    localparam int Y_W       = 31;
    localparam int Y_FRAC    = Y_W - 1;
    localparam int EXP_STEPS = LOG_FRAC;
    localparam int EXP_N_MIN = -10;
    localparam int SHIFT_W   = $clog2(Y_FRAC - EXP_N_MIN + 1);
    localparam int RND_W     = Y_FRAC - EXP_N_MIN + 1;

    localparam int FILL_W     = $clog2(TAPS + 1);
    localparam int REG_IDX_W  = $clog2(NUM_WEIGHTS);
    localparam int CFG_ADDR_W = REG_IDX_W + 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [SAMPLE_W-1:0] ONE_Q12      = SAMPLE_W'(1 << SAMPLE_FRAC);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(13107);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WEIGHT_0 = REG_IDX_W'(0),
        REG_WEIGHT_1 = REG_IDX_W'(1),
        REG_WEIGHT_2 = REG_IDX_W'(2),
        REG_WEIGHT_3 = REG_IDX_W'(3),
        REG_WEIGHT_4 = REG_IDX_W'(4)
    } reg_index_t;

    typedef struct packed {
        logic                valid;
        logic                zero;
        logic [MSB_W-1:0]    msb;
        logic [SAMPLE_W-1:0] sample;
    } log_side_t;

    typedef struct packed {
        logic                    zero;
        logic [SAMPLE_W-1:0]     sample;
        logic signed [LOG_W-1:0] lval;
    } tap_t;

    typedef struct packed {
        logic                valid;
        logic                zero;
        logic                full;
        logic [SAMPLE_W-1:0] centre;
    } win_side_t;

    typedef struct packed {
        logic                valid;
        logic                zero;
        logic                sat;
        logic [SHIFT_W-1:0]  shift;
        logic                full;
        logic [SAMPLE_W-1:0] centre;
    } exp_side_t;

    typedef struct packed {
        logic                window_full;
        logic [SAMPLE_W-1:0] deviation;
        logic [SAMPLE_W-1:0] step_change;
        logic [SAMPLE_W-1:0] filtered;
    } result_t;

    // 2^(2^-(k+1)) in Q1.30
    function automatic logic [Y_W-1:0] exp_factor(input int k);
        logic [Y_W-1:0] f;
        case (k)
            0:       f = Y_W'(1518500250);
            1:       f = Y_W'(1276901417);
            2:       f = Y_W'(1170923762);
            3:       f = Y_W'(1121280436);
            4:       f = Y_W'(1097253708);
            5:       f = Y_W'(1085434106);
            6:       f = Y_W'(1079572136);
            7:       f = Y_W'(1076653033);
            8:       f = Y_W'(1075196443);
            9:       f = Y_W'(1074468888);
            10:      f = Y_W'(1074105294);
            11:      f = Y_W'(1073923544);
            12:      f = Y_W'(1073832680);
            13:      f = Y_W'(1073787251);
            14:      f = Y_W'(1073764537);
            15:      f = Y_W'(1073753181);
            default: f = Y_W'(1 << Y_FRAC);
        endcase
        return f;
    endfunction

endpackage

// ----- hw/rtl/weighted_geometric_mean_filter_core.sv -----
// Weighted geometric mean filter core.
// Throughput one item per cycle: the log2 chain (17 squaring cells), the window row and
// the exp2 chain (16 factor cells) all advance together every cycle that the skid is empty.
// Reset: window slots read 1.0, weights 13107, previous output 0, fill count 0,
// pipeline and output empty. No clearing pass.
// Depends on wgm_pkg, wgm_log_cell, wgm_tap_cell, wgm_exp_cell and the defines header.
`include "weighted_geometric_mean_filter_core_defines.svh"

module weighted_geometric_mean_filter_core
    import wgm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // stream in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
    // stream out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [3*SAMPLE_W-1:0] m_axis_tdata,   // [15:0] filtered, [31:16] step_change,
                                                  // [47:32] deviation
    output logic                  m_axis_tuser,   // [0] window_full
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic signed [N_W-1:0] N_SAT   = N_W'(SAMPLE_W);
    localparam logic signed [N_W-1:0] N_LOW   = N_W'(EXP_N_MIN);
    localparam logic signed [N_W-1:0] N_BIAS  = N_W'(SAMPLE_FRAC);
    localparam logic signed [N_W-1:0] N_SHIFT = N_W'(Y_FRAC);
    localparam logic [ACC_W-1:0]      E_HALF  = ACC_W'(1) << (LOG_FRAC - 1);
    localparam logic [SAMPLE_W-1:0]   OUT_MAX = '1;

    // ---------------- configuration ----------------
    logic [WEIGHT_W-1:0] weight_reg  [NUM_WEIGHTS];
    logic [WEIGHT_W-1:0] weight_next [NUM_WEIGHTS];
    logic [WEIGHT_W-1:0] tap_weight  [TAPS];
    reg_index_t          cfg_idx;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_idx   = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        weight_next = weight_reg;
        if (cfg_write) begin
            case (cfg_idx)
                REG_WEIGHT_0: weight_next[0] = pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_1: weight_next[1] = pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_2: weight_next[2] = pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_3: weight_next[3] = pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_4: weight_next[4] = pwdata[WEIGHT_W-1:0];
                default:      weight_next = weight_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WEIGHT_0: prdata = CFG_DATA_W'(weight_reg[0]);
            REG_WEIGHT_1: prdata = CFG_DATA_W'(weight_reg[1]);
            REG_WEIGHT_2: prdata = CFG_DATA_W'(weight_reg[2]);
            REG_WEIGHT_3: prdata = CFG_DATA_W'(weight_reg[3]);
            REG_WEIGHT_4: prdata = CFG_DATA_W'(weight_reg[4]);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                weight_reg[i] <= WEIGHT_RESET;
            end
        end
        else begin
            weight_reg <= weight_next;
        end
    end

    // ---------------- pipeline advance ----------------
    logic    en;
    logic    emit;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    result_t result;

    // the whole chain moves unless the skid already holds an item
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // ---------------- normalise ----------------
    log_side_t           norm_side_next;
    logic [MSB_W-1:0]    msb_next;
    logic [SAMPLE_W-1:0] norm_val;

    always_comb begin
        msb_next = '0;
        for (int i = 0; i < SAMPLE_W; i++) begin
            if (s_axis_tdata[i]) begin
                msb_next = MSB_W'(i);
            end
        end
    end

    assign norm_val              = s_axis_tdata << (MSB_W'(SAMPLE_W - 1) - msb_next);
    assign norm_side_next.valid  = s_axis_tvalid;
    assign norm_side_next.zero   = (s_axis_tdata == '0);
    assign norm_side_next.msb    = msb_next;
    assign norm_side_next.sample = s_axis_tdata;

    log_side_t         log_side [LOG_STEPS+1];
    logic [Z_W-1:0]    log_z    [LOG_STEPS+1];
    logic [FRAC_W-1:0] log_frac [LOG_STEPS+1];
    logic [Z_W-1:0]    norm_z_reg;
    log_side_t         norm_side_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            norm_side_reg <= '0;
        end
        else if (en) begin
            norm_side_reg <= norm_side_next;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            norm_z_reg <= {norm_val, {(Z_W - SAMPLE_W){1'b0}}};
        end
    end

    assign log_side[0] = norm_side_reg;
    assign log_z[0]    = norm_z_reg;
    assign log_frac[0] = '0;

    // ---------------- log2 chain ----------------
    for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
        wgm_log_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (log_side[k]),
            .z_in     (log_z[k]),
            .frac_in  (log_frac[k]),
            .side_out (log_side[k+1]),
            .z_out    (log_z[k+1]),
            .frac_out (log_frac[k+1])
        );
    end

    // ---------------- window row ----------------
    log_side_t                       log_end;
    logic [FRAC_W:0]                 frac_round;
    logic signed [LOG_W-LOG_FRAC-1:0] log_int;
    tap_t                            new_tap;
    tap_t                            tap_q    [TAPS];
    logic signed [PROD_W-1:0]        tap_prod [TAPS];
    logic                            shift;
    logic                            win_valid_reg;
    logic [FILL_W-1:0]               fill_count_reg;
    logic [FILL_W-1:0]               fill_count_next;

    assign log_end    = log_side[LOG_STEPS];
    assign frac_round = {1'b0, log_frac[LOG_STEPS]} + (FRAC_W + 1)'(1);
    assign log_int    = $signed({1'b0, log_end.msb}) - (LOG_W - LOG_FRAC)'(SAMPLE_FRAC);

    assign new_tap.zero   = log_end.zero;
    assign new_tap.sample = log_end.sample;
    assign new_tap.lval   = $signed({log_int, {LOG_FRAC{1'b0}}})
                          + $signed({{(LOG_W - FRAC_W){1'b0}}, frac_round[FRAC_W:1]});

    assign shift = en && log_end.valid;

    for (genvar i = 0; i < TAPS; i++) begin : g_tap
        if (i < NUM_WEIGHTS) begin : g_w
            assign tap_weight[i] = weight_reg[i];
        end
        else begin : g_nw
            assign tap_weight[i] = '0;
        end

        if (i == TAPS - 1) begin : g_head
            wgm_tap_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .en      (en),
                .tap_in  (new_tap),
                .weight  (tap_weight[i]),
                .tap_out (tap_q[i]),
                .product (tap_prod[i])
            );
        end
        else begin : g_body
            wgm_tap_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .en      (en),
                .tap_in  (tap_q[i+1]),
                .weight  (tap_weight[i]),
                .tap_out (tap_q[i]),
                .product (tap_prod[i])
            );
        end
    end

    assign fill_count_next = (fill_count_reg < FILL_W'(TAPS))
                           ? fill_count_reg + FILL_W'(1) : fill_count_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fill_count_reg <= '0;
        end
        else if (shift) begin
            fill_count_reg <= fill_count_next;
        end
    end

    // mark that the window row holds a fresh item for the product stage
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            win_valid_reg <= 1'b0;
        end
        else if (en) begin
            win_valid_reg <= log_end.valid;
        end
    end

    // ---------------- product and sum stages ----------------
    win_side_t               prod_side_next;
    win_side_t               prod_side_reg;
    win_side_t               sum_side_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] acc_reg;

    always_comb begin
        prod_side_next.valid  = win_valid_reg;
        prod_side_next.full   = (fill_count_reg == FILL_W'(TAPS));
        prod_side_next.centre = tap_q[CENTRE].sample;
        prod_side_next.zero   = 1'b0;
        for (int i = 0; i < TAPS; i++) begin
            prod_side_next.zero = prod_side_next.zero | tap_q[i].zero;
        end
    end

    always_comb begin
        acc_next = '0;
        for (int i = 0; i < TAPS; i++) begin
            acc_next = acc_next + ACC_W'(tap_prod[i]);
        end
    end

    // the product stage registers the shifted window row, ahead of the sum stage
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prod_side_reg <= '0;
            sum_side_reg  <= '0;
        end
        else if (en) begin
            prod_side_reg <= prod_side_next;
            sum_side_reg  <= prod_side_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            acc_reg <= acc_next;
        end
    end

    // ---------------- exponent split ----------------
    logic [ACC_W-1:0]              e_round;
    logic [E_W-1:0]                e_val;
    logic signed [N_W-1:0]         n_val;
    logic signed [N_W-1:0]         s_val;
    exp_side_t                     exp_side_next;
    exp_side_t                     exp_side [EXP_STEPS+1];
    logic [Y_W-1:0]                exp_y    [EXP_STEPS+1];
    logic [EXP_STEPS-1:0]          exp_f    [EXP_STEPS+1];
    exp_side_t                     e_side_reg;
    logic [EXP_STEPS-1:0]          e_f_reg;

    assign e_round = acc_reg + E_HALF;
    assign e_val   = e_round[ACC_W-1:LOG_FRAC];
    assign n_val   = $signed({e_val[E_W-1], e_val[E_W-1:LOG_FRAC]}) + N_BIAS;
    assign s_val   = N_SHIFT - n_val;

    assign exp_side_next.valid  = sum_side_reg.valid;
    assign exp_side_next.zero   = sum_side_reg.zero || (n_val < N_LOW);
    assign exp_side_next.sat    = (n_val >= N_SAT);
    assign exp_side_next.shift  = s_val[SHIFT_W-1:0];
    assign exp_side_next.full   = sum_side_reg.full;
    assign exp_side_next.centre = sum_side_reg.centre;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            e_side_reg <= '0;
        end
        else if (en) begin
            e_side_reg <= exp_side_next;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            e_f_reg <= e_val[EXP_STEPS-1:0];
        end
    end

    assign exp_side[0] = e_side_reg;
    assign exp_y[0]    = Y_W'(1) << Y_FRAC;
    assign exp_f[0]    = e_f_reg;

    // ---------------- exp2 chain ----------------
    for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
        wgm_exp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .factor   (exp_factor(k)),
            .side_in  (exp_side[k]),
            .y_in     (exp_y[k]),
            .f_in     (exp_f[k]),
            .side_out (exp_side[k+1]),
            .y_out    (exp_y[k+1]),
            .f_out    (exp_f[k+1])
        );
    end

    // ---------------- final rounding ----------------
    exp_side_t           exp_end;
    logic [RND_W-1:0]    rnd_sum;
    logic [RND_W-1:0]    rnd_val;
    logic [SAMPLE_W-1:0] filt_next;
    win_side_t           fin_side_next;
    win_side_t           fin_side_reg;
    logic [SAMPLE_W-1:0] fin_filt_reg;

    assign exp_end = exp_side[EXP_STEPS];
    assign rnd_sum = RND_W'(exp_y[EXP_STEPS])
                   + (RND_W'(1) << (exp_end.shift - SHIFT_W'(1)));
    assign rnd_val = rnd_sum >> exp_end.shift;

    always_comb begin
        if (exp_end.zero) begin
            filt_next = '0;
        end
        else if (exp_end.sat || (|rnd_val[RND_W-1:SAMPLE_W])) begin
            filt_next = OUT_MAX;
        end
        else begin
            filt_next = rnd_val[SAMPLE_W-1:0];
        end
    end

    assign fin_side_next.valid  = exp_end.valid;
    assign fin_side_next.zero   = exp_end.zero;
    assign fin_side_next.full   = exp_end.full;
    assign fin_side_next.centre = exp_end.centre;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fin_side_reg <= '0;
        end
        else if (en) begin
            fin_side_reg <= fin_side_next;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            fin_filt_reg <= filt_next;
        end
    end

    // ---------------- Manhattan terms and output ----------------
    logic [SAMPLE_W-1:0] prev_out_reg;

    assign emit = en && fin_side_reg.valid;

    assign result.filtered    = fin_filt_reg;
    assign result.window_full = fin_side_reg.full;
    assign result.step_change = (fin_filt_reg > prev_out_reg) ? fin_filt_reg - prev_out_reg
                                                              : prev_out_reg - fin_filt_reg;
    assign result.deviation   = (fin_filt_reg > fin_side_reg.centre)
                              ? fin_filt_reg - fin_side_reg.centre
                              : fin_side_reg.centre - fin_filt_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_axis_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else begin
                out_valid_next = emit;
                out_data_next  = result;
            end
        end
        else if (emit) begin
            // output still waiting: park the item in the skid
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            prev_out_reg   <= '0;
        end
        else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (emit) begin
                prev_out_reg <= fin_filt_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.deviation, out_data_reg.step_change,
                            out_data_reg.filtered};
    assign m_axis_tuser  = out_data_reg.window_full;

    // ---------------- assertions ----------------
    `WGM_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid holds an item while the output register is empty")
    `WGM_ASSERT_IMP(a_fill_bound, 1'b1, fill_count_reg <= FILL_W'(TAPS),
        "fill count ran past the tap count")
    `WGM_ASSERT_NXT(a_fill_sticky, fill_count_reg == FILL_W'(TAPS),
        fill_count_reg == FILL_W'(TAPS), "window full flag dropped")
    `WGM_ASSERT_NXT(a_out_held, out_valid_reg && !m_axis_tready, out_valid_reg,
        "waiting result lost")
    `WGM_ASSERT_NXT(a_park_in_skid, emit && out_valid_reg && !m_axis_tready, skid_valid_reg,
        "emitted item not parked while output stalled")

endmodule

// ----- hw/rtl/wgm_log_cell.sv -----
// One squaring step of the log2 chain: yields one fraction bit per item.
// Depends on wgm_pkg.
module wgm_log_cell
    import wgm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  log_side_t         side_in,
    input  logic [Z_W-1:0]    z_in,
    input  logic [FRAC_W-1:0] frac_in,
    output log_side_t         side_out,
    output logic [Z_W-1:0]    z_out,
    output logic [FRAC_W-1:0] frac_out
);

    localparam logic [2*Z_W-1:0] HALF = (2*Z_W)'(1) << (Z_FRAC - 1);

    log_side_t         side_reg;
    logic [Z_W-1:0]    z_reg;
    logic [Z_W-1:0]    z_next;
    logic [FRAC_W-1:0] frac_reg;
    logic [FRAC_W-1:0] frac_next;
    logic [2*Z_W-1:0]  square;
    logic [2*Z_W-1:0]  scaled;
    logic [Z_W:0]      rounded;
    logic              bit_next;

    assign square    = (2*Z_W)'(z_in) * (2*Z_W)'(z_in);
    assign scaled    = (square + HALF) >> Z_FRAC;
    assign rounded   = scaled[Z_W:0];
    // a square of two or more renormalises and sets the bit
    assign bit_next  = rounded[Z_W];
    assign z_next    = bit_next ? rounded[Z_W:1] : rounded[Z_W-1:0];
    assign frac_next = {frac_in[FRAC_W-2:0], bit_next};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            side_reg <= '0;
        end
        else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            z_reg    <= z_next;
            frac_reg <= frac_next;
        end
    end

    assign side_out = side_reg;
    assign z_out    = z_reg;
    assign frac_out = frac_reg;

endmodule

// ----- hw/rtl/wgm_tap_cell.sv -----
// One window slot: holds a sample with its log2 and forms the weighted log.
// Depends on wgm_pkg.
module wgm_tap_cell
    import wgm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift,
    input  logic                     en,
    input  tap_t                     tap_in,
    input  logic [WEIGHT_W-1:0]      weight,
    output tap_t                     tap_out,
    output logic signed [PROD_W-1:0] product
);

    tap_t                     tap_reg;
    logic signed [PROD_W-1:0] product_reg;
    logic signed [PROD_W-1:0] product_next;
    logic signed [PROD_W-1:0] w_ext;
    logic signed [PROD_W-1:0] l_ext;

    assign w_ext        = PROD_W'($signed({1'b0, weight}));
    assign l_ext        = PROD_W'($signed(tap_reg.lval));
    assign product_next = w_ext * l_ext;

    // empty slots hold 1.0, whose log is zero
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tap_reg.zero   <= 1'b0;
            tap_reg.sample <= ONE_Q12;
            tap_reg.lval   <= '0;
        end
        else if (shift) begin
            tap_reg <= tap_in;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            product_reg <= product_next;
        end
    end

    assign tap_out = tap_reg;
    assign product = product_reg;

endmodule

// ----- hw/rtl/wgm_exp_cell.sv -----
// One factor step of the exp2 chain: applies 2^(2^-(k+1)) when its bit is set.
// Depends on wgm_pkg.
module wgm_exp_cell
    import wgm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [Y_W-1:0]       factor,
    input  exp_side_t            side_in,
    input  logic [Y_W-1:0]       y_in,
    input  logic [EXP_STEPS-1:0] f_in,
    output exp_side_t            side_out,
    output logic [Y_W-1:0]       y_out,
    output logic [EXP_STEPS-1:0] f_out
);

    localparam logic [2*Y_W-1:0] HALF = (2*Y_W)'(1) << (Y_FRAC - 1);

    exp_side_t            side_reg;
    logic [Y_W-1:0]       y_reg;
    logic [Y_W-1:0]       y_next;
    logic [EXP_STEPS-1:0] f_reg;
    logic [EXP_STEPS-1:0] f_next;
    logic [2*Y_W-1:0]     prod;
    logic [2*Y_W-1:0]     rounded;

    assign prod    = (2*Y_W)'(y_in) * (2*Y_W)'(factor);
    assign rounded = (prod + HALF) >> Y_FRAC;
    // the running product stays below 2.0, so the top bits are spare
    assign y_next  = f_in[EXP_STEPS-1] ? rounded[Y_W-1:0] : y_in;
    assign f_next  = {f_in[EXP_STEPS-2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            side_reg <= '0;
        end
        else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            y_reg <= y_next;
            f_reg <= f_next;
        end
    end

    assign side_out = side_reg;
    assign y_out    = y_reg;
    assign f_out    = f_reg;

endmodule
